@@ hdl/tmtw_pkg.sv @@
package tmtw_pkg;

    // Item commands.
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes with a meaning of their own.
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] TAB_CHAR     = 8'd9;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    // Tab advance in columns.
    localparam int unsigned TAB_STEP = 4;

    // Attribute after reset and for the screen clear at reset.
    localparam logic [7:0] RESET_COLOR = 8'h07;

    typedef logic [15:0] t_cell;

    function automatic t_cell make_cell(input logic [7:0] ch, input logic [7:0] color);
        make_cell = {color, ch};
    endfunction

endpackage

@@ hdl/text_mode_terminal_writer.sv @@
// Character terminal over a ROWS x COLUMNS text screen memory of 16-bit cells
// (character in the low byte, attribute in the high byte).
// Input channel: i_in_valid / o_in_stall with i_cmd, i_char_code and
// i_cell_index. A put handles one character at the cursor; a read returns one
// cell. Every item produces exactly one result transfer on o_out_valid /
// i_out_stall, carrying the cursor position, the cell read and a scroll flag.
// The attribute for written cells comes from i_cfg_data, loaded whenever
// i_cfg_we is high; reset loads light grey on black.
// Results: a put that does not scroll shows its result in the cycle after the
// transfer, so such puts can follow back to back. A read passes through the
// registered read port of the screen memory and then the S_READ state before
// its result is registered. A put that scrolls sweeps the single-write,
// single-read memory once before the result.
// Reset: i_rst_n is synchronous and active low. After it, a clearing pass
// writes a grey blank to every cell, one cell a cycle, while no item is
// taken; configuration writes still land.
// When the receiver stalls, the finished result is held in the output register
// and the next item is taken only at the edge at which that result transfers.
module text_mode_terminal_writer #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_pos,
    output logic [15:0] o_cell_value,
    output logic        o_scrolled
);

    localparam int unsigned CELLS     = ROWS * COLUMNS;
    localparam int unsigned AW        = $clog2(CELLS);
    localparam int unsigned PW        = (AW > 11) ? AW : 11;
    localparam int unsigned CW        = $clog2(COLUMNS);
    localparam int unsigned NCW       = CW + 1;
    localparam int unsigned RW        = $clog2(ROWS);
    localparam int unsigned COPIES    = CELLS - COLUMNS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL
    } t_state;

    // Screen memory: one write port, one registered read port.
    tmtw_pkg::t_cell r_mem [CELLS];
    tmtw_pkg::t_cell r_mem_q;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    tmtw_pkg::t_cell mem_wd;
    logic [AW-1:0]   mem_ra;

    t_state          r_state, n_state;
    logic [7:0]      r_text_color;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_base, n_base;   // r_row * COLUMNS, kept incrementally
    logic [AW-1:0]   r_sweep, n_sweep; // clear, copy and fill position
    logic            r_rd_ok, n_rd_ok;
    logic            r_out_valid, n_out_valid;
    logic [10:0]     r_out_pos, n_out_pos;
    tmtw_pkg::t_cell r_out_value, n_out_value;
    logic            r_out_scrolled, n_out_scrolled;

    logic            accept;
    logic [NCW-1:0]  col_adv;
    logic            row_adv;
    logic            do_scroll;
    logic [PW-1:0]   idx_ext;
    logic [PW-1:0]   cur_pos;
    logic [PW-1:0]   next_pos;
    logic [AW:0]     src_addr;

    // A new item may enter only when idle and the output slot is free or
    // empties at this same edge.
    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;

    assign idx_ext  = PW'(i_cell_index);
    assign cur_pos  = PW'(r_base) + PW'(r_col);
    assign src_addr = (AW + 1)'(r_sweep) + (AW + 1)'(COLUMNS);

    // Cursor advance for a put in this cycle.
    always_comb begin
        col_adv = NCW'(r_col);
        row_adv = 1'b0;
        if (i_char_code == tmtw_pkg::NEWLINE_CHAR) begin
            col_adv = '0;
            row_adv = 1'b1;
        end else if (i_char_code == tmtw_pkg::TAB_CHAR) begin
            col_adv = NCW'(r_col) + NCW'(tmtw_pkg::TAB_STEP);
        end else begin
            col_adv = NCW'(r_col) + NCW'(1);
        end
        // Wrapping at the right edge drops any tab excess.
        if (col_adv >= NCW'(COLUMNS)) begin
            col_adv = '0;
            row_adv = 1'b1;
        end
        do_scroll = row_adv && (r_row == RW'(ROWS - 1));
    end

    assign next_pos = PW'(n_base) + PW'(n_col);

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_col          = r_col;
        n_base         = r_base;
        n_sweep        = r_sweep;
        n_rd_ok        = r_rd_ok;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_pos      = r_out_pos;
        n_out_value    = r_out_value;
        n_out_scrolled = r_out_scrolled;
        mem_we         = 1'b0;
        mem_wa         = cur_pos[AW-1:0];
        mem_wd         = tmtw_pkg::make_cell(i_char_code, r_text_color);
        mem_ra         = idx_ext[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_sweep;
                mem_wd = tmtw_pkg::make_cell(tmtw_pkg::BLANK_CHAR, tmtw_pkg::RESET_COLOR);
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == AW'(CELLS - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == tmtw_pkg::CMD_READ) begin
                        n_rd_ok = idx_ext < PW'(CELLS);
                        n_state = S_READ;
                    end else begin
                        // The character lands before any scroll moves it up.
                        mem_we = (i_char_code != tmtw_pkg::NEWLINE_CHAR) &&
                                 (i_char_code != tmtw_pkg::TAB_CHAR);
                        n_col = col_adv[CW-1:0];
                        if (row_adv && !do_scroll) begin
                            n_row  = r_row + RW'(1);
                            n_base = r_base + AW'(COLUMNS);
                        end
                        if (do_scroll) begin
                            n_sweep = '0;
                            n_state = S_SCROLL;
                        end else begin
                            n_out_valid    = 1'b1;
                            n_out_pos      = next_pos[10:0];
                            n_out_value    = '0;
                            n_out_scrolled = 1'b0;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid    = 1'b1;
                n_out_pos      = cur_pos[10:0];
                n_out_value    = r_rd_ok ? r_mem_q : '0;
                n_out_scrolled = 1'b0;
                n_state        = S_IDLE;
            end
            S_SCROLL: begin
                // Read one row below the sweep point, write the previous
                // cycle's data one cell behind it.
                mem_ra = src_addr[AW-1:0];
                mem_wa = r_sweep - AW'(1);
                mem_wd = r_mem_q;
                mem_we = (r_sweep != '0);
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == AW'(COPIES)) begin
                    n_sweep = AW'(COPIES);
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_sweep;
                mem_wd = tmtw_pkg::make_cell(tmtw_pkg::BLANK_CHAR, r_text_color);
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == AW'(CELLS - 1)) begin
                    n_sweep        = '0;
                    n_out_valid    = 1'b1;
                    n_out_pos      = cur_pos[10:0];
                    n_out_value    = '0;
                    n_out_scrolled = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_text_color <= tmtw_pkg::RESET_COLOR;
            r_row        <= '0;
            r_col        <= '0;
            r_base       <= '0;
            r_sweep      <= '0;
            r_rd_ok      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_sweep     <= n_sweep;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_text_color <= i_cfg_data;
            end
        end
        r_out_pos      <= n_out_pos;
        r_out_value    <= n_out_value;
        r_out_scrolled <= n_out_scrolled;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_value = r_out_value;
    assign o_scrolled   = r_out_scrolled;

    // The incremental row base always matches the row.
    a_base_matches_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_base) == PW'(r_row) * PW'(COLUMNS))
        else $error("row base out of step with cursor row");

    // The cursor never rests past the last row or column.
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= RW'(ROWS - 1)) && (r_col <= CW'(COLUMNS - 1)))
        else $error("cursor left the screen");

    // A scroll result leaves the cursor at column 0 of the last row.
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (r_row == RW'(ROWS - 1)) && (r_col == '0))
        else $error("scroll left the cursor off the last row start");

    // No new item is taken while the writer is busy outside the idle state.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("item taken while busy");

    // A read result follows its transfer once the registered memory read has passed through S_READ.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == tmtw_pkg::CMD_READ)) |=> ##1 o_out_valid)
        else $error("read result missing");

endmodule
